/* hdl/rofr_pkg.sv */
// Package for the rectangle rasterizer: widths, command and status codes,
// register indexes and the sequencer state type. No dependencies.
package rofr_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int FRAC_BITS  = 8;
  localparam int SIDE_W     = $clog2(MAX_SIDE);      // row/col index bits
  localparam int ADDR_W     = 2 * SIDE_W;            // canvas store address
  localparam int SIZE_W     = 9;                     // canvas size register
  localparam int FX_W       = 24;                    // input fixed-point fields
  localparam int CRD_W      = FX_W + 3;              // room for x+w and +/- one
  localparam int STEP_W     = 3;
  localparam int SETUP_STEPS = 6;

  localparam logic signed [CRD_W-1:0] ONE_FX = CRD_W'(1) << FRAC_BITS;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIDE);

  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_SIZE  = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_W = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_H = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BG       = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DRAW,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

/* hdl/rectangle_outline_fill_rasterizer_unit.sv */
// Rectangle rasterizer top level: canvas store, bound setup on a shared
// adder, pixel sweep sequencer and result register. Uses rofr_pkg.
//
//  channel | direction | contents
//  in_     | slave     | tuser: opcode; tdata: corner_x, corner_y, rect_width,
//          |           |   rect_height, filled, paint_byte, read_row, read_col
//  out_    | master    | tdata: status, pixel_byte
//  cfg_    | write-only| cfg_addr register index, cfg_data value
//
// Draw: accept, then bound setup on the one adder, then a sweep over the
//   whole canvas window, writing each painted pixel, then load the result.
// Clear: accept, then all 65536 store entries, one per cycle, then load the
//   result. Read: accept, store read, load the result.
// Size error and no-op: accept, then load the result. Ready only while idle.
// rst_n is synchronous; the canvas store holds garbage until the first clear.
// A result waiting on out_tready holds the sequencer in its last state.
module rectangle_outline_fill_rasterizer_unit
  import rofr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [23:0] corner_x, [47:24] corner_y, [71:48] rect_width, [95:72] rect_height,
  // [96] filled, [104:97] paint_byte, [112:105] read_row, [120:113] read_col
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] status, [9:2] pixel_byte
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // input field unpack
  logic [FX_W-1:0]   f_x, f_y, f_w, f_h;
  logic              f_fill;
  logic [7:0]        f_paint;
  logic [SIDE_W-1:0] f_rrow, f_rcol;
  opcode_t           f_op;

  assign f_x     = in_tdata[23:0];
  assign f_y     = in_tdata[47:24];
  assign f_w     = in_tdata[71:48];
  assign f_h     = in_tdata[95:72];
  assign f_fill  = in_tdata[96];
  assign f_paint = in_tdata[104:97];
  assign f_rrow  = in_tdata[112:105];
  assign f_rcol  = in_tdata[120:113];
  assign f_op    = opcode_t'(in_tuser);

  // configuration
  logic [SIZE_W-1:0] cw_r, ch_r;
  logic [7:0]        bg_r;
  logic [SIZE_W-1:0] cfg_side;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0)           cfg_side = SIZE_W'(1);
    else if (cfg_data > SIZE_MAX) cfg_side = SIZE_MAX;
    else                          cfg_side = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= SIZE_W'(1);
      ch_r <= SIZE_W'(1);
      bg_r <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_CANVAS_W: cw_r <= cfg_side;
        REG_CANVAS_H: ch_r <= cfg_side;
        REG_BG:       bg_r <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [SIDE_W-1:0]        row_r, row_nxt, col_r, col_nxt;
  logic signed [CRD_W-1:0]  x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  logic signed [CRD_W-1:0]  xr_r, xr_nxt, yb_r, yb_nxt;
  logic signed [CRD_W-1:0]  xi_r, xi_nxt, yi_r, yi_nxt;
  logic signed [CRD_W-1:0]  xri_r, xri_nxt, ybi_r, ybi_nxt;
  logic                     fill_r, fill_nxt;
  logic [7:0]               paint_r, paint_nxt;
  status_t                  sts_r, sts_nxt;
  logic                     use_rd_r, use_rd_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic [OUT_DATA_W-1:0]    odata_r, odata_nxt;

  // shared setup adder
  logic signed [CRD_W-1:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  always_comb begin
    case (step_r)
      3'd0:    begin add_a = x_r;  add_b = w_r;     end
      3'd1:    begin add_a = y_r;  add_b = h_r;     end
      3'd2:    begin add_a = x_r;  add_b = ONE_FX;  end
      3'd3:    begin add_a = y_r;  add_b = ONE_FX;  end
      3'd4:    begin add_a = xr_r; add_b = -ONE_FX; end
      3'd5:    begin add_a = yb_r; add_b = -ONE_FX; end
      default: begin add_a = '0;   add_b = '0;      end
    endcase
  end

  // pixel classification
  logic signed [CRD_W-1:0] px, py;
  logic in_rect, border, paint;
  logic col_last, row_last, clr_last;

  assign px = CRD_W'(col_r) << FRAC_BITS;
  assign py = CRD_W'(row_r) << FRAC_BITS;
  assign in_rect = (px >= x_r) && (px <= xr_r) && (py >= y_r) && (py <= yb_r);
  // less than one pixel from any edge
  assign border = (px < xi_r) || (px > xri_r) || (py < yi_r) || (py > ybi_r);
  assign paint  = in_rect && (border || fill_r);

  assign col_last = ({1'b0, col_r} == cw_r - SIZE_W'(1));
  assign row_last = ({1'b0, row_r} == ch_r - SIZE_W'(1));
  assign clr_last = (row_r == '1) && (col_r == '1);

  // canvas store
  logic [7:0]        mem [MAX_SIDE*MAX_SIDE];
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        rd_data_r;

  assign mem_addr = {row_r, col_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    xr_nxt     = xr_r;
    yb_nxt     = yb_r;
    xi_nxt     = xi_r;
    yi_nxt     = yi_r;
    xri_nxt    = xri_r;
    ybi_nxt    = ybi_r;
    fill_nxt   = fill_r;
    paint_nxt  = paint_r;
    sts_nxt    = sts_r;
    use_rd_nxt = use_rd_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    mem_we     = 1'b0;
    mem_wdata  = paint_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt      = {{(CRD_W-FX_W){f_x[FX_W-1]}}, f_x};
          y_nxt      = {{(CRD_W-FX_W){f_y[FX_W-1]}}, f_y};
          w_nxt      = {{(CRD_W-FX_W){f_w[FX_W-1]}}, f_w};
          h_nxt      = {{(CRD_W-FX_W){f_h[FX_W-1]}}, f_h};
          fill_nxt   = f_fill;
          paint_nxt  = f_paint;
          sts_nxt    = STS_OK;
          use_rd_nxt = 1'b0;
          step_nxt   = '0;
          row_nxt    = '0;
          col_nxt    = '0;
          case (f_op)
            OP_DRAW: begin
              if (f_w[FX_W-1] || f_w == '0 || f_h[FX_W-1] || f_h == '0) begin
                sts_nxt   = STS_SIZE;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SETUP;
              end
            end
            OP_READ: begin
              row_nxt = f_rrow;
              col_nxt = f_rcol;
              if ({1'b0, f_rrow} >= ch_r || {1'b0, f_rcol} >= cw_r) begin
                sts_nxt   = STS_RANGE;
                state_nxt = ST_DONE;
              end else begin
                use_rd_nxt = 1'b1;
                state_nxt  = ST_READ;
              end
            end
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SETUP: begin
        case (step_r)
          3'd0:    xr_nxt  = add_sum;
          3'd1:    yb_nxt  = add_sum;
          3'd2:    xi_nxt  = add_sum;
          3'd3:    yi_nxt  = add_sum;
          3'd4:    xri_nxt = add_sum;
          default: ybi_nxt = add_sum;
        endcase
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SETUP_STEPS - 1)) state_nxt = ST_DRAW;
      end

      ST_DRAW: begin
        mem_we = paint;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) state_nxt = ST_DONE;
          else          row_nxt   = row_r + SIDE_W'(1);
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = bg_r;
        {row_nxt, col_nxt} = mem_addr + ADDR_W'(1);
        if (clr_last) state_nxt = ST_DONE;
      end

      ST_READ: state_nxt = ST_DONE;   // store read data lands in rd_data_r

      ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {6'd0, (use_rd_r ? rd_data_r : 8'd0), sts_r};
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    xr_r     <= xr_nxt;
    yb_r     <= yb_nxt;
    xi_r     <= xi_nxt;
    yi_r     <= yi_nxt;
    xri_r    <= xri_nxt;
    ybi_r    <= ybi_nxt;
    fill_r   <= fill_nxt;
    paint_r  <= paint_nxt;
    sts_r    <= sts_nxt;
    use_rd_r <= use_rd_nxt;
    odata_r  <= odata_nxt;
  end

endmodule

/* hdl/rofr_checker.sv */
// Port-level checks for the rectangle rasterizer, bound to its top level.
// Uses rofr_pkg for status codes.
module rofr_checker
  import rofr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // one command at a time: ready drops right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] == STS_OK || out_tdata[1:0] == STS_SIZE ||
                   out_tdata[1:0] == STS_RANGE)
    else $error("illegal status code");

  a_err_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STS_OK |-> out_tdata[9:2] == 8'd0)
    else $error("error result carries pixel data");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rectangle_outline_fill_rasterizer_unit rofr_checker u_rofr_checker (.*);

/* test/tb_rectangle_outline_fill_rasterizer_unit.sv */
// Self-checking bench for rectangle_outline_fill_rasterizer_unit: a canvas-mirroring
// scoreboard class plus stream, config and sink tasks around the DUT.
// Depends on rofr_pkg and the DUT only.
`timescale 1ns / 100ps

import rofr_pkg::*;

typedef struct {
  opcode_t                op;
  logic signed [FX_W-1:0] corner_x;
  logic signed [FX_W-1:0] corner_y;
  logic signed [FX_W-1:0] rect_w;
  logic signed [FX_W-1:0] rect_h;
  logic                   filled;
  logic [7:0]             paint;
  logic [7:0]             read_row;
  logic [7:0]             read_col;
} raster_cmd_t;

typedef struct {
  opcode_t    op;
  status_t    status;
  logic [7:0] pixel;
} raster_result_t;

typedef enum {PIX_OUT, PIX_EDGE, PIX_INNER} pix_class_t;

class canvas_scoreboard;
  logic [7:0]     canvas [MAX_SIDE*MAX_SIDE];
  int unsigned    cols;
  int unsigned    rows;
  logic [7:0]     bg;
  raster_result_t awaited_results [$];
  int             op_count [4];
  int             checked;
  int             errors;

  function new();
    cols = 1;
    rows = 1;
    bg = 8'd32;
    checked = 0;
    errors = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (canvas[i]) canvas[i] = 8'd0;
  endfunction

  function int unsigned side_of(logic [CFG_DATA_W-1:0] val);
    if (val == 0) return 1;
    if (val > MAX_SIDE) return MAX_SIDE;
    return val;
  endfunction

  function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CANVAS_W: cols = side_of(val);
      REG_CANVAS_H: rows = side_of(val);
      REG_BG:       bg = val[7:0];
      default: ;
    endcase
  endfunction

  function pix_class_t classify(longint x, y, w, h, px, py);
    longint one, right, bottom;
    one = longint'(1) << FRAC_BITS;
    right = x + w;
    bottom = y + h;
    if (px < x || px > right || py < y || py > bottom) return PIX_OUT;
    // border band: closer than one pixel to any edge
    if (px - x < one || right - px < one || py - y < one || bottom - py < one)
      return PIX_EDGE;
    return PIX_INNER;
  endfunction

  function void note_command(raster_cmd_t cmd);
    raster_result_t res;
    longint x, y, w, h;
    int unsigned r, c;
    pix_class_t k;
    res.op = cmd.op;
    res.status = STS_OK;
    res.pixel = 8'd0;
    op_count[cmd.op]++;
    case (cmd.op)
      OP_DRAW: begin
        x = cmd.corner_x;
        y = cmd.corner_y;
        w = cmd.rect_w;
        h = cmd.rect_h;
        if (w <= 0 || h <= 0) begin
          res.status = STS_SIZE;
        end else begin
          for (r = 0; r < rows; r++)
            for (c = 0; c < cols; c++) begin
              k = classify(x, y, w, h, longint'(c) << FRAC_BITS, longint'(r) << FRAC_BITS);
              if (k == PIX_EDGE || (k == PIX_INNER && cmd.filled))
                canvas[r * MAX_SIDE + c] = cmd.paint;
            end
        end
      end
      OP_READ: begin
        if (cmd.read_row >= rows || cmd.read_col >= cols)
          res.status = STS_RANGE;
        else
          res.pixel = canvas[cmd.read_row * MAX_SIDE + cmd.read_col];
      end
      OP_CLEAR: begin
        // clear hits the whole store, not just the active window
        foreach (canvas[i]) canvas[i] = bg;
      end
      default: ;
    endcase
    awaited_results.push_back(res);
  endfunction

  function void check_result(logic [1:0] status, logic [7:0] pixel);
    raster_result_t want;
    checked++;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result beat %0d with nothing outstanding: status %0d pixel 0x%02h",
                 checked, status, pixel);
      return;
    end
    want = awaited_results.pop_front();
    if (want.status !== status || want.pixel !== pixel) begin
      errors++;
      if (errors <= 10)
        $display("result %0d (%s): status exp %0d got %0d, pixel exp 0x%02h got 0x%02h",
                 checked, want.op.name(), want.status, status, want.pixel, pixel);
    end
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction
endclass

module tb_rectangle_outline_fill_rasterizer_unit;

  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold_req = 1'b0;

  canvas_scoreboard sb = new();

  rectangle_outline_fill_rasterizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int tx_gap();
    return tx_idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  // every field random, so unused bits toggle too
  function automatic raster_cmd_t rand_cmd();
    raster_cmd_t cmd;
    cmd.op = opcode_t'($urandom_range(0, 3));
    cmd.corner_x = FX_W'($urandom);
    cmd.corner_y = FX_W'($urandom);
    cmd.rect_w = FX_W'($urandom);
    cmd.rect_h = FX_W'($urandom);
    cmd.filled = 1'($urandom_range(0, 1));
    cmd.paint = 8'($urandom);
    cmd.read_row = 8'($urandom);
    cmd.read_col = 8'($urandom);
    return cmd;
  endfunction

  function automatic raster_cmd_t op_cmd(opcode_t op);
    raster_cmd_t cmd;
    cmd = rand_cmd();
    cmd.op = op;
    return cmd;
  endfunction

  function automatic raster_cmd_t draw_cmd(int x, int y, int w, int h, bit fill,
                                           logic [7:0] paint);
    raster_cmd_t cmd;
    cmd = op_cmd(OP_DRAW);
    cmd.corner_x = FX_W'(x);
    cmd.corner_y = FX_W'(y);
    cmd.rect_w = FX_W'(w);
    cmd.rect_h = FX_W'(h);
    cmd.filled = fill;
    cmd.paint = paint;
    return cmd;
  endfunction

  function automatic raster_cmd_t read_cmd(int row, int col);
    raster_cmd_t cmd;
    cmd = op_cmd(OP_READ);
    cmd.read_row = 8'(row);
    cmd.read_col = 8'(col);
    return cmd;
  endfunction

  function automatic int shaped_origin(int unsigned cells);
    return int'($urandom_range(0, (cells + 4) * 256)) - 512;
  endfunction

  function automatic int shaped_span(int unsigned cells);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 511);           // under two pixels
      1:       return 256 * $urandom_range(1, 4);       // whole pixels
      default: return $urandom_range(1, (cells + 4) * 256);
    endcase
  endfunction

  function automatic raster_cmd_t shaped_draw();
    return draw_cmd(shaped_origin(sb.cols), shaped_origin(sb.rows), shaped_span(sb.cols),
                    shaped_span(sb.rows), 1'($urandom_range(0, 1)), 8'($urandom));
  endfunction

  function automatic raster_cmd_t shaped_read();
    if ($urandom_range(0, 9) < 7)
      return read_cmd($urandom_range(0, sb.rows - 1), $urandom_range(0, sb.cols - 1));
    return read_cmd($urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(input raster_cmd_t cmd, input int gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd.op;
    in_tdata = IN_DATA_W'({cmd.read_col, cmd.read_row, cmd.paint, cmd.filled,
                           cmd.rect_h, cmd.rect_w, cmd.corner_y, cmd.corner_x});
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result sink: per-beat random stall, or one long hold-off on request
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        stall = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 18) : 0;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata[1:0], out_tdata[9:2]);
    end
  end

  initial begin : watchdog
    #6_000_000;
    $display("watchdog expired with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    raster_cmd_t cmd;
    int clears_left;
    int big_draws_left;
    int settings;
    int kind;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    clears_left = 1;
    big_draws_left = 2;
    settings = 1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset canvas is 1x1 with background 32
    send_cmd(op_cmd(OP_CLEAR), tx_gap());
    send_cmd(read_cmd(0, 0), tx_gap());
    send_cmd(read_cmd(0, 1), tx_gap());
    send_cmd(read_cmd(1, 0), tx_gap());

    wait_results();
    write_reg(REG_CANVAS_W, 9'd8);
    write_reg(REG_CANVAS_H, 9'd6);
    settings++;
    send_cmd(draw_cmd(256, 256, 1024, 768, 1, 8'hAA), tx_gap());
    send_cmd(draw_cmd(128, 128, 1536, 1024, 0, 8'h55), tx_gap());
    send_cmd(draw_cmd(512, 512, 256, 256, 1, 8'h11), tx_gap());       // one pixel on a side, touches 2x2 pixels
    send_cmd(draw_cmd(1536, -128, 128, 512, 0, 8'h22), tx_gap());     // thinner than a pixel
    send_cmd(draw_cmd(0, 0, 8388607, 8388607, 0, 8'h33), tx_gap());
    send_cmd(draw_cmd(-8388608, -8388608, 8388607, 8388607, 1, 8'h44), tx_gap());
    send_cmd(draw_cmd(8388607, 0, 256, 256, 1, 8'h66), tx_gap());
    send_cmd(draw_cmd(256, 256, 0, 512, 1, 8'h77), tx_gap());
    send_cmd(draw_cmd(256, 256, 512, -8388608, 1, 8'h77), tx_gap());
    send_cmd(draw_cmd(256, 256, -256, -256, 0, 8'hFF), tx_gap());
    send_cmd(op_cmd(OP_NOP), tx_gap());
    send_cmd(read_cmd(0, 0), tx_gap());
    send_cmd(read_cmd(1, 1), tx_gap());
    send_cmd(read_cmd(2, 3), tx_gap());
    send_cmd(read_cmd(5, 7), tx_gap());
    send_cmd(read_cmd(3, 2), tx_gap());
    send_cmd(read_cmd(6, 0), tx_gap());
    send_cmd(read_cmd(0, 8), tx_gap());
    send_cmd(read_cmd(255, 255), tx_gap());

    for (int p = 0; p < 8; p++) begin
      wait_results();
      case (p)
        0: begin  // out-of-range sizes clamp to 1 and the max
          write_reg(REG_CANVAS_W, 9'd0);
          write_reg(REG_CANVAS_H, 9'd300);
          write_reg(REG_BG, 9'd0);
        end
        1: begin
          write_reg(REG_CANVAS_W, 9'd511);
          write_reg(REG_CANVAS_H, 9'd2);
          write_reg(REG_BG, 9'd255);
        end
        2: begin
          write_reg(REG_CANVAS_W, 9'd256);
          write_reg(REG_CANVAS_H, 9'd256);
        end
        default: begin
          write_reg(REG_CANVAS_W, CFG_DATA_W'($urandom_range(1, 20)));
          write_reg(REG_CANVAS_H, CFG_DATA_W'($urandom_range(1, 20)));
          write_reg(REG_BG, CFG_DATA_W'($urandom_range(0, 511)));
        end
      endcase
      settings++;
      tx_idle_on = (p != 4 && p != 6);
      rx_idle_on = (p != 5 && p != 6);

      if (p == 3) begin
        // sink stalls long while commands keep coming: input must back up
        rx_hold_req = 1'b1;
        repeat (6) send_cmd(shaped_read(), 0);
      end

      for (int i = 0; i < 10; i++) begin
        kind = $urandom_range(0, 99);
        if (p <= 1 && i == 0) begin
          cmd = op_cmd(OP_CLEAR);
        end else if (kind < 55 && (sb.cols * sb.rows <= 8192 || big_draws_left > 0)) begin
          if (sb.cols * sb.rows > 8192) big_draws_left--;
          if (kind < 45) begin
            cmd = shaped_draw();
          end else begin
            cmd = op_cmd(OP_DRAW);
          end
        end else if (kind < 90) begin
          cmd = shaped_read();
        end else if (kind < 96 || clears_left == 0) begin
          cmd = op_cmd(OP_NOP);
        end else begin
          clears_left--;
          cmd = op_cmd(OP_CLEAR);
        end
        send_cmd(cmd, tx_gap());
        if (p == 5 && i == 4) wait_results();
      end
    end

    wait_results();
    repeat (64) @(posedge clk);
    $display("covered %0d draws, %0d reads, %0d clears, %0d no-ops over %0d canvas settings",
             sb.op_count[OP_DRAW], sb.op_count[OP_READ], sb.op_count[OP_CLEAR],
             sb.op_count[OP_NOP], settings);
    $display("checked %0d result beats, %0d failures, %0d still outstanding",
             sb.checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rofr_pkg.sv
hdl/rectangle_outline_fill_rasterizer_unit.sv
hdl/rofr_checker.sv
test/tb_rectangle_outline_fill_rasterizer_unit.sv
